### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL. Defining ASSERT_OFF
// removes every assertion from the build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### rtl/pstab_pkg.sv
// ----------------------------------------------------------------------------
// Priority sorted device table package
// Command, result and state codes plus the types shared by the cell chain
// and the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pstab_pkg;

	// Command codes; codes 6 and 7 are unused and change nothing.
	typedef enum logic [2:0] {
		OP_ADD        = 3'd0,
		OP_DELETE     = 3'd1,
		OP_ACTIVATE   = 3'd2,
		OP_DEACTIVATE = 3'd3,
		OP_SET_ERROR  = 3'd4,
		OP_LOOKUP     = 3'd5
	} op_t;

	// Result codes.
	typedef enum logic [2:0] {
		RC_OK             = 3'd0,
		RC_NOT_FOUND      = 3'd1,
		RC_ALREADY_ACTIVE = 3'd2,
		RC_NOT_ACTIVE     = 3'd3,
		RC_FULL           = 3'd4,
		RC_BAD_PRIORITY   = 3'd5
	} rc_t;

	// Device states.
	typedef enum logic [1:0] {
		ST_ACTIVE   = 2'd0,
		ST_INACTIVE = 2'd1,
		ST_ERROR    = 2'd2,
		ST_PENDING  = 2'd3
	} st_t;

	localparam logic [15:0] ID_START = 16'd1001;
	localparam logic [3:0]  PRIO_MIN = 4'd1;
	localparam logic [3:0]  PRIO_MAX = 4'd10;

	// One table entry as held by a cell.
	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [3:0]  prio;
		logic [2:0]  dtype;
		st_t         state;
	} entry_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic        exec;
		op_t         op;
		logic [15:0] target_id;
		logic [3:0]  prio;
		logic [2:0]  dtype;
		logic [15:0] new_id;
	} cmd_t;

	// Search result passed along the chain toward its tail.
	typedef struct packed {
		logic       hit;
		logic [3:0] prio;
		logic [2:0] dtype;
		st_t        state;
	} find_t;

	// Virtual neighbor ahead of the first cell: valid at top priority.
	localparam entry_t HEAD_ENTRY = '{valid: 1'b1, id: 16'd0, prio: 4'hF,
		dtype: 3'd0, state: ST_ACTIVE};

	// Virtual neighbor behind the last cell: an empty entry.
	localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, id: 16'd0, prio: 4'd0,
		dtype: 3'd0, state: ST_ACTIVE};

	localparam find_t NO_FIND = '{hit: 1'b0, prio: 4'd0, dtype: 3'd0,
		state: ST_ACTIVE};

endpackage

`default_nettype wire

### rtl/pstab_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one entry of the sorted table. Shifts toward the tail on insert and
// toward the head on delete, and passes the first ID match down the chain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pstab_cell import pstab_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   cmd,
	input  wire entry_t left_entry,
	input  wire logic   left_ge,
	input  wire entry_t right_entry,
	input  wire find_t  find_in,
	output entry_t      entry,
	output logic        ge,
	output find_t       find_out
);

	entry_t entry_q;
	entry_t entry_d;
	logic   match;
	logic   first;

	assign entry = entry_q;

	// Local compares against the broadcast command.
	assign ge    = entry_q.valid && (entry_q.prio >= cmd.prio);
	assign match = entry_q.valid && (entry_q.id == cmd.target_id);
	assign first = match && !find_in.hit;

	// The first matching cell puts its fields on the chain.
	always_comb begin
		find_out.hit = find_in.hit | match;
		if (first) begin
			find_out.prio  = entry_q.prio;
			find_out.dtype = entry_q.dtype;
			find_out.state = entry_q.state;
		end else begin
			find_out.prio  = find_in.prio;
			find_out.dtype = find_in.dtype;
			find_out.state = find_in.state;
		end
	end

	// Next entry for each command.
	always_comb begin
		entry_d = entry_q;
		unique case (cmd.op)
			OP_ADD: begin
				if (!ge) begin
					if (left_ge) begin
						entry_d.valid = 1'b1;
						entry_d.id    = cmd.new_id;
						entry_d.prio  = cmd.prio;
						entry_d.dtype = cmd.dtype;
						entry_d.state = ST_PENDING;
					end else begin
						entry_d = left_entry;
					end
				end
			end
			OP_DELETE: begin
				if (find_out.hit) begin
					entry_d = right_entry;
				end
			end
			OP_ACTIVATE: begin
				if (first) begin
					entry_d.state = ST_ACTIVE;
				end
			end
			OP_DEACTIVATE: begin
				if (first && entry_q.state == ST_ACTIVE) begin
					entry_d.state = ST_INACTIVE;
				end
			end
			OP_SET_ERROR: begin
				if (first) begin
					entry_d.state = ST_ERROR;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// Entry register; reset empties the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= EMPTY_ENTRY;
		end else if (cmd.exec) begin
			entry_q <= entry_d;
		end
	end

	// Valid entries stay packed at the head of the chain.
	`ASSERT_CLK(a_cell_packed, clk, arst_n, !left_entry.valid |-> !entry_q.valid, "cell valid after empty neighbor")

	// The chain stays sorted by priority, highest first.
	`ASSERT_NEVER(a_cell_sorted, clk, arst_n, left_entry.valid && entry_q.valid && (left_entry.prio < entry_q.prio), "table out of priority order")

endmodule

`default_nettype wire

### rtl/pstab_ctrl.sv
// ----------------------------------------------------------------------------
// Table controller
// Command register, ID counter, entry counts and result register. Broadcasts
// each command to the cell chain and forms the result from the chain tail.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pstab_ctrl import pstab_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [2:0]   opcode,
	input  wire logic [15:0]  device_id,
	input  wire logic [3:0]   priority_req,
	input  wire logic [2:0]   device_type,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [2:0]        result_code,
	output logic [15:0]       assigned_id,
	output logic [3:0]        found_priority,
	output logic [2:0]        found_type,
	output logic [1:0]        found_state,
	output logic [4:0]        total_count,
	output logic [4:0]        active_count,
	output cmd_t              cmd,
	input  wire find_t        find
);

	localparam int COUNT_W = $clog2(CAPACITY + 1);

	logic               cmd_valid_q;
	op_t                op_q;
	logic [15:0]        target_q;
	logic [3:0]         prio_q;
	logic [2:0]         dtype_q;
	logic [15:0]        id_ctr_q;
	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] active_q;
	logic               out_valid_q;
	rc_t                rc_q;
	logic [15:0]        new_id_q;
	logic [3:0]         fp_q;
	logic [2:0]         ft_q;
	st_t                fs_q;

	logic               exec;
	logic               apply;
	rc_t                rc_d;
	logic [15:0]        new_id_d;
	logic [3:0]         fp_d;
	logic [2:0]         ft_d;
	st_t                fs_d;
	logic [15:0]        id_ctr_d;
	logic [COUNT_W-1:0] total_d;
	logic [COUNT_W-1:0] active_d;

	// One command in flight; it runs once the result register is free.
	assign in_ready = !cmd_valid_q;
	assign exec     = cmd_valid_q && (!out_valid_q || out_ready);

	// Command broadcast to the cells.
	assign cmd.exec      = exec && apply;
	assign cmd.op        = op_q;
	assign cmd.target_id = target_q;
	assign cmd.prio      = prio_q;
	assign cmd.dtype     = dtype_q;
	assign cmd.new_id    = id_ctr_q;

	// Result and counter updates from the chain tail.
	always_comb begin
		apply    = 1'b1;
		rc_d     = RC_OK;
		new_id_d = 16'd0;
		fp_d     = 4'd0;
		ft_d     = 3'd0;
		fs_d     = ST_ACTIVE;
		id_ctr_d = id_ctr_q;
		total_d  = total_q;
		active_d = active_q;
		unique case (op_q)
			OP_ADD: begin
				if (prio_q < PRIO_MIN || prio_q > PRIO_MAX) begin
					apply = 1'b0;
					rc_d  = RC_BAD_PRIORITY;
				end else if (total_q == COUNT_W'(CAPACITY)) begin
					apply = 1'b0;
					rc_d  = RC_FULL;
				end else begin
					new_id_d = id_ctr_q;
					id_ctr_d = id_ctr_q + 16'd1;
					total_d  = total_q + COUNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (!find.hit) begin
					rc_d = RC_NOT_FOUND;
				end else begin
					total_d = total_q - COUNT_W'(1);
					if (find.state == ST_ACTIVE) begin
						active_d = active_q - COUNT_W'(1);
					end
				end
			end
			OP_ACTIVATE: begin
				if (!find.hit) begin
					rc_d = RC_NOT_FOUND;
				end else if (find.state == ST_ACTIVE) begin
					rc_d = RC_ALREADY_ACTIVE;
				end else begin
					active_d = active_q + COUNT_W'(1);
				end
			end
			OP_DEACTIVATE: begin
				if (!find.hit) begin
					rc_d = RC_NOT_FOUND;
				end else if (find.state != ST_ACTIVE) begin
					rc_d = RC_NOT_ACTIVE;
				end else begin
					active_d = active_q - COUNT_W'(1);
				end
			end
			OP_SET_ERROR: begin
				if (!find.hit) begin
					rc_d = RC_NOT_FOUND;
				end else if (find.state == ST_ACTIVE) begin
					active_d = active_q - COUNT_W'(1);
				end
			end
			OP_LOOKUP: begin
				if (!find.hit) begin
					rc_d = RC_NOT_FOUND;
				end else begin
					fp_d = find.prio;
					ft_d = find.dtype;
					fs_d = find.state;
				end
			end
			default: begin
				apply = 1'b1;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			id_ctr_q    <= ID_START;
			total_q     <= '0;
			active_q    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				cmd_valid_q <= 1'b1;
			end else if (exec) begin
				cmd_valid_q <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
				id_ctr_q    <= id_ctr_d;
				total_q     <= total_d;
				active_q    <= active_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= op_t'(opcode);
			target_q <= device_id;
			prio_q   <= priority_req;
			dtype_q  <= device_type;
		end
		if (exec) begin
			rc_q     <= rc_d;
			new_id_q <= new_id_d;
			fp_q     <= fp_d;
			ft_q     <= ft_d;
			fs_q     <= fs_d;
		end
	end

	// Output beat; counts reflect the last executed command.
	assign out_valid      = out_valid_q;
	assign result_code    = rc_q;
	assign assigned_id    = new_id_q;
	assign found_priority = fp_q;
	assign found_type     = ft_q;
	assign found_state    = fs_q;
	assign total_count    = 5'(total_q);
	assign active_count   = 5'(active_q);

	`ASSERT_CLK(a_total_cap, clk, arst_n, total_q <= COUNT_W'(CAPACITY), "entry count above capacity")

	`ASSERT_CLK(a_active_le_total, clk, arst_n, active_q <= total_q, "active count above entry count")

	`ASSERT_CLK(a_id_advance, clk, arst_n, (exec && op_q == OP_ADD && rc_d == RC_OK) |=> (id_ctr_q == $past(id_ctr_q) + 16'd1), "ID counter did not advance on add")

	`ASSERT_CLK(a_id_only_ok, clk, arst_n, (out_valid_q && rc_q != RC_OK) |-> (new_id_q == 16'd0), "assigned ID on a failed command")

endmodule

`default_nettype wire

### rtl/priority_sorted_device_table_unit.sv
// ----------------------------------------------------------------------------
// Priority sorted device table
// Command input channel (opcode, device_id, priority_req, device_type) and
// result output channel (result_code, assigned_id, found fields, counts),
// both valid/ready.
// Each command is first registered from its input beat; then the whole cell
// chain compares, shifts or updates in parallel as the result register loads.
// The next command is accepted the cycle after execution, so no new command is
// taken while one waits to run. The first-match search ripples through the
// chain, so the clock period grows with CAPACITY.
// A result waits in its register while the receiver stalls; one further
// command may be accepted meanwhile and runs once the result is taken.
// Reset empties the table, clears both counts and sets the next ID to 1001.
// Counts are reported in five bits and wrap when CAPACITY exceeds 31.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_sorted_device_table_unit import pstab_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [15:0] device_id,
	input  wire logic [3:0]  priority_req,
	input  wire logic [2:0]  device_type,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       result_code,
	output logic [15:0]      assigned_id,
	output logic [3:0]       found_priority,
	output logic [2:0]       found_type,
	output logic [1:0]       found_state,
	output logic [4:0]       total_count,
	output logic [4:0]       active_count
);

	cmd_t   cmd;
	entry_t ent     [CAPACITY];
	entry_t left_e  [CAPACITY];
	entry_t right_e [CAPACITY];
	logic   ge      [CAPACITY];
	logic   left_ge [CAPACITY];
	find_t  fnd_in  [CAPACITY];
	find_t  fnd_out [CAPACITY];

	// Controller with counters and result register.
	pstab_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.device_id      (device_id),
		.priority_req   (priority_req),
		.device_type    (device_type),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_code    (result_code),
		.assigned_id    (assigned_id),
		.found_priority (found_priority),
		.found_type     (found_type),
		.found_state    (found_state),
		.total_count    (total_count),
		.active_count   (active_count),
		.cmd            (cmd),
		.find           (fnd_out[CAPACITY-1])
	);

	// Row of cells, head first.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_e[i]  = HEAD_ENTRY;
			assign left_ge[i] = 1'b1;
			assign fnd_in[i]  = NO_FIND;
		end else begin : g_body
			assign left_e[i]  = ent[i-1];
			assign left_ge[i] = ge[i-1];
			assign fnd_in[i]  = fnd_out[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e[i] = EMPTY_ENTRY;
		end else begin : g_next
			assign right_e[i] = ent[i+1];
		end

		pstab_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_entry  (left_e[i]),
			.left_ge     (left_ge[i]),
			.right_entry (right_e[i]),
			.find_in     (fnd_in[i]),
			.entry       (ent[i]),
			.ge          (ge[i]),
			.find_out    (fnd_out[i])
		);
	end

endmodule

`default_nettype wire
